### hdl/rcpd_pkg.sv
// Package for the RC pulse capture / dethermal block.
// Holds the item, result, state and configuration types and the reset constants.
// No dependencies.
`default_nettype none

package rcpd_pkg;

	// Bit positions inside pin_levels
	localparam int SERVO_BIT = 0;
	localparam int ESC_BIT   = 1;

	// Configuration reset values
	localparam logic [15:0] SERVO_LONG_THR_RST = 16'd1500;
	localparam logic [15:0] ESC_RUN_THR_RST    = 16'd1400;
	localparam logic [7:0]  DT_LIMIT_RST       = 8'd10;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SERVO_LONG_THR = 2'd0,
		REG_ESC_RUN_THR    = 2'd1,
		REG_DT_COUNT_LIMIT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  pin_levels;
		logic [31:0] now_us;
		logic [31:0] now_ms;
	} evt_t;

	typedef struct packed {
		logic [31:0] servo_width_us;
		logic [31:0] esc_width_us;
		logic [31:0] period_us;
		logic [31:0] dethermal_elapsed_ms;
		logic [31:0] motor_run_ms;
	} res_t;

	typedef struct packed {
		logic [1:0]  addr;
		logic [15:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [15:0] servo_long_threshold_us;
		logic [15:0] esc_run_threshold_us;
		logic [7:0]  dethermal_count_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  prev_levels;
		logic [31:0] rise_time_us;
		logic [31:0] servo_width;
		logic [31:0] esc_width;
		logic [31:0] period_len;
		logic [31:0] dethermal_start_ms;
		logic [31:0] esc_start_ms;
		logic [31:0] dethermal_elapsed;
		logic [31:0] motor_elapsed;
		logic [8:0]  long_pulse_count;
	} state_t;

endpackage

`default_nettype wire

### hdl/rcpd_if.sv
// Channel interfaces for the RC pulse capture / dethermal block.
// Event input, result output and configuration write channels.
// Depends on rcpd_pkg.
`default_nettype none

interface rcpd_evt_if import rcpd_pkg::*; ();
	logic valid;
	logic ready;
	evt_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rcpd_res_if import rcpd_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rcpd_cfg_if import rcpd_pkg::*; ();
	logic    valid;
	logic    ready;
	cfg_wr_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/rcpd_update.sv
// Next-state logic for one pin-change event: edge detect, width/period
// measurement, long-pulse counter and dethermal/motor timing.
// Depends on rcpd_pkg.
`default_nettype none

module rcpd_update import rcpd_pkg::*; (
	input  var state_t st,
	input  var cfg_t   cf,
	input  var evt_t   ev,
	output state_t     nxt
);

	logic [1:0]  chg;
	logic [31:0] servo_dt;
	logic [31:0] esc_dt;

	always_comb begin
		nxt = st;
		chg = ev.pin_levels ^ st.prev_levels;
		nxt.prev_levels = ev.pin_levels;
		servo_dt = ev.now_us - st.rise_time_us;

		// Servo edge first
		if (chg[SERVO_BIT]) begin
			if (!ev.pin_levels[SERVO_BIT]) begin
				nxt.servo_width = servo_dt;
				if (st.dethermal_start_ms != 32'd0) begin
					nxt.dethermal_elapsed = ev.now_ms - st.dethermal_start_ms;
				end
				if (servo_dt > {16'd0, cf.servo_long_threshold_us}) begin
					if (st.long_pulse_count > {1'b0, cf.dethermal_count_limit}) begin
						nxt.dethermal_start_ms = 32'd0;
						nxt.long_pulse_count   = 9'd0;
					end
					if (nxt.dethermal_start_ms != 32'd0) begin
						nxt.long_pulse_count = nxt.long_pulse_count + 9'd1;
					end
				end else if (st.long_pulse_count != 9'd0) begin
					nxt.long_pulse_count = st.long_pulse_count - 9'd1;
				end
			end else begin
				nxt.period_len   = servo_dt;
				nxt.rise_time_us = ev.now_us;
			end
		end

		// ESC falling edge, measured from the (possibly just updated) servo rise
		esc_dt = ev.now_us - nxt.rise_time_us;
		if (chg[ESC_BIT] && !ev.pin_levels[ESC_BIT]) begin
			nxt.esc_width = esc_dt;
			if (esc_dt > {16'd0, cf.esc_run_threshold_us}) begin
				nxt.motor_elapsed      = ev.now_ms - st.esc_start_ms;
				nxt.dethermal_start_ms = st.esc_start_ms;
			end else if (esc_dt < {16'd0, cf.esc_run_threshold_us}) begin
				nxt.esc_start_ms = ev.now_ms;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/rc_pulse_capture_dethermal_core.sv
// Top level of the RC pulse capture / dethermal block.
// Input register, next-state logic (rcpd_update), state and result registers.
// Depends on rcpd_pkg, rcpd_if and rcpd_update.
//
//  channel | dir | payload                                   | transfer
//  --------+-----+-------------------------------------------+------------------
//  evt     | in  | pin_levels, now_us, now_ms                | valid & ready
//  res     | out | servo/esc width, period, dethermal, motor | valid & ready
//  cfg     | in  | addr (register index), wdata              | valid & ready
//
// One event per cycle sustained while results are taken. An event is taken into
// the input stage, and when it advances its state update and result are written
// together into the state and result registers. Reset clears state and valid
// flags and loads the configuration defaults. A stalled result holds; the input
// stage still takes one more event behind it, and the event channel stalls only
// when both are full.
`default_nettype none

module rc_pulse_capture_dethermal_core import rcpd_pkg::*; (
	input  var logic   clk,
	input  var logic   arst_n,
	rcpd_evt_if.sink   evt,
	rcpd_res_if.source res,
	rcpd_cfg_if.sink   cfg
);

	evt_t   evt_s1;
	logic   valid_s1;
	state_t state_q;
	state_t state_nxt;
	cfg_t   cfg_q;
	res_t   res_q;
	logic   res_valid_q;
	logic   advance;

	// Move the input stage into the result register when it is free or drained
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= evt.data;
		end
	end

	// Configuration registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.servo_long_threshold_us <= SERVO_LONG_THR_RST;
			cfg_q.esc_run_threshold_us    <= ESC_RUN_THR_RST;
			cfg_q.dethermal_count_limit   <= DT_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.data.addr)
				REG_SERVO_LONG_THR: cfg_q.servo_long_threshold_us <= cfg.data.wdata;
				REG_ESC_RUN_THR:    cfg_q.esc_run_threshold_us    <= cfg.data.wdata;
				REG_DT_COUNT_LIMIT: cfg_q.dethermal_count_limit   <= cfg.data.wdata[7:0];
				default: ;
			endcase
		end
	end

	rcpd_update u_update (
		.st  (state_q),
		.cf  (cfg_q),
		.ev  (evt_s1),
		.nxt (state_nxt)
	);

	// Measurement state: advance once per event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: valid flag under reset, payload loads with the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.servo_width_us       <= state_nxt.servo_width;
			res_q.esc_width_us         <= state_nxt.esc_width;
			res_q.period_us            <= state_nxt.period_len;
			res_q.dethermal_elapsed_ms <= state_nxt.dethermal_elapsed;
			res_q.motor_run_ms         <= state_nxt.motor_elapsed;
		end
	end

	// An empty input stage never blocks the event channel
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> evt.ready)
		else $error("event channel stalled with empty input stage");

	// A new result only appears from an occupied input stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("result produced without an event");

	// Long-pulse counter advances only while at most the limit, so it never passes 256
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.long_pulse_count <= 9'd256)
		else $error("long-pulse counter out of range");

endmodule

`default_nettype wire

### tb/sv/rcpd_capture_checker.sv
// Scoreboard for the RC pulse capture / dethermal block: mirrors the capture state,
// predicts one result per event transfer and compares it with the result channel.
// Depends on rcpd_pkg and rcpd_if.
`timescale 1ns / 100ps

module rcpd_capture_checker import rcpd_pkg::*; (
	input  var logic clk,
	input  var logic arst_n,
	rcpd_evt_if      evt,
	rcpd_res_if      res,
	rcpd_cfg_if      cfg,
	output int       mismatch_cnt,
	output int       outstanding,
	output int       checked_cnt
);

	cfg_t   thr;
	state_t pst;
	res_t   pending_readings[$];
	res_t   want;

	// Advance the mirrored capture state by one pin-change event.
	function automatic res_t capture_event(input evt_t e);
		logic [1:0] flips;
		res_t       r;
		flips = e.pin_levels ^ pst.prev_levels;
		pst.prev_levels = e.pin_levels;
		if (flips[SERVO_BIT]) begin
			if (!e.pin_levels[SERVO_BIT]) begin
				pst.servo_width = e.now_us - pst.rise_time_us;
				if (pst.dethermal_start_ms != 32'd0)
					pst.dethermal_elapsed = e.now_ms - pst.dethermal_start_ms;
				if (pst.servo_width > {16'd0, thr.servo_long_threshold_us}) begin
					if (pst.long_pulse_count > {1'b0, thr.dethermal_count_limit}) begin
						pst.dethermal_start_ms = 32'd0;
						pst.long_pulse_count   = 9'd0;
					end
					if (pst.dethermal_start_ms != 32'd0)
						pst.long_pulse_count = pst.long_pulse_count + 9'd1;
				end else if (pst.long_pulse_count != 9'd0) begin
					pst.long_pulse_count = pst.long_pulse_count - 9'd1;
				end
			end else begin
				pst.period_len   = e.now_us - pst.rise_time_us;
				pst.rise_time_us = e.now_us;
			end
		end
		if (flips[ESC_BIT] && !e.pin_levels[ESC_BIT]) begin
			pst.esc_width = e.now_us - pst.rise_time_us;
			if (pst.esc_width > {16'd0, thr.esc_run_threshold_us}) begin
				pst.motor_elapsed      = e.now_ms - pst.esc_start_ms;
				pst.dethermal_start_ms = pst.esc_start_ms;
			end else if (pst.esc_width < {16'd0, thr.esc_run_threshold_us}) begin
				pst.esc_start_ms = e.now_ms;
			end
		end
		r.servo_width_us       = pst.servo_width;
		r.esc_width_us         = pst.esc_width;
		r.period_us            = pst.period_len;
		r.dethermal_elapsed_ms = pst.dethermal_elapsed;
		r.motor_run_ms         = pst.motor_elapsed;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr.servo_long_threshold_us = SERVO_LONG_THR_RST;
			thr.esc_run_threshold_us    = ESC_RUN_THR_RST;
			thr.dethermal_count_limit   = DT_LIMIT_RST;
			pst = '0;
			pending_readings.delete();
			mismatch_cnt = 0;
			checked_cnt  = 0;
			outstanding  = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (pending_readings.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: result with nothing pending: %h", $time, res.data);
				end else begin
					want = pending_readings.pop_front();
					checked_cnt++;
					if (want !== res.data) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("%0t: result %0d mismatch (exp / got)", $time, checked_cnt);
							$display("  servo_width_us       %h / %h",
								want.servo_width_us, res.data.servo_width_us);
							$display("  esc_width_us         %h / %h",
								want.esc_width_us, res.data.esc_width_us);
							$display("  period_us            %h / %h",
								want.period_us, res.data.period_us);
							$display("  dethermal_elapsed_ms %h / %h",
								want.dethermal_elapsed_ms, res.data.dethermal_elapsed_ms);
							$display("  motor_run_ms         %h / %h",
								want.motor_run_ms, res.data.motor_run_ms);
						end
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.addr)
					REG_SERVO_LONG_THR: thr.servo_long_threshold_us = cfg.data.wdata;
					REG_ESC_RUN_THR:    thr.esc_run_threshold_us    = cfg.data.wdata;
					REG_DT_COUNT_LIMIT: thr.dethermal_count_limit   = cfg.data.wdata[7:0];
					default: ;
				endcase
			end
			if (evt.valid && evt.ready)
				pending_readings.push_back(capture_event(evt.data));
			outstanding = pending_readings.size();
		end
	end

endmodule

### tb/sv/tb_rc_pulse_capture_dethermal_core.sv
// Testbench top for rc_pulse_capture_dethermal_core: drives pin-change events and
// register writes, applies random back-pressure, and reports the verdict.
// Depends on rcpd_pkg, rcpd_if, the core and rcpd_capture_checker.
`timescale 1ns / 100ps

module tb_rc_pulse_capture_dethermal_core;
	import rcpd_pkg::*;

	logic        clk;
	logic        arst_n;
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;
	int          n_sent = 0;
	int          mismatch_cnt;
	int          outstanding;
	int          checked_cnt;
	// Timebase that the event generator advances
	logic [31:0] cur_us;
	logic [31:0] cur_ms;
	// Thresholds currently programmed, used to aim pulse widths near them
	logic [15:0] servo_thr_now;
	logic [15:0] esc_thr_now;

	rcpd_evt_if evt_ch ();
	rcpd_res_if res_ch ();
	rcpd_cfg_if cfg_ch ();

	rc_pulse_capture_dethermal_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	rcpd_capture_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt          (evt_ch),
		.res          (res_ch),
		.cfg          (cfg_ch),
		.mismatch_cnt (mismatch_cnt),
		.outstanding  (outstanding),
		.checked_cnt  (checked_cnt)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Result back-pressure: drop ready at random, at the rate the current phase asks
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Hold one event on the channel until it transfers. Called at a falling edge,
	// returns at a falling edge with valid still high, so back-to-back events keep
	// valid asserted without a glitch.
	task automatic send_evt(input logic [1:0] lv, input logic [31:0] us, input logic [31:0] ms);
		evt_t e;
		e.pin_levels = lv;
		e.now_us     = us;
		e.now_ms     = ms;
		while ($urandom_range(99) < src_idle_pct) begin
			evt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.data  <= e;
		@(posedge clk);
		while (!evt_ch.ready)
			@(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	// Program all three registers once the block has drained. Valid stays high
	// across the three writes and drops after the last one.
	task automatic apply_setting(input logic [15:0] servo_thr, input logic [15:0] esc_thr,
			input logic [7:0] dt_limit);
		reg_idx_t    idx  [3];
		logic [15:0] vals [3];
		idx[0]  = REG_SERVO_LONG_THR;
		idx[1]  = REG_ESC_RUN_THR;
		idx[2]  = REG_DT_COUNT_LIMIT;
		vals[0] = servo_thr;
		vals[1] = esc_thr;
		vals[2] = {8'd0, dt_limit};
		evt_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		for (int k = 0; k < 3; k++) begin
			cfg_ch.valid      <= 1'b1;
			cfg_ch.data.addr  <= idx[k];
			cfg_ch.data.wdata <= vals[k];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_ch.valid  <= 1'b0;
		servo_thr_now = servo_thr;
		esc_thr_now   = esc_thr;
	endtask

	// Mostly well-formed servo/ESC frames with widths straddling the thresholds,
	// the rest random pin noise with full-range timestamps.
	task automatic run_frames(input int quota);
		int          stop;
		int          d;
		logic [31:0] t0;
		logic [31:0] sw;
		logic [31:0] ew;
		stop = n_sent + quota;
		while (n_sent < stop) begin
			if ($urandom_range(9) < 2) begin
				t0     = $urandom_range(1) ? $urandom : cur_us + $urandom_range(5000);
				cur_ms = $urandom_range(1) ? $urandom : cur_ms + $urandom_range(3);
				cur_us = t0;
				send_evt(2'($urandom_range(3)), t0, cur_ms);
			end else begin
				t0 = cur_us + $urandom_range(3000, 25000);
				cur_ms = cur_ms + $urandom_range(1, 40);
				// Favor long servo pulses so the long-pulse counter climbs past its limit
				if ($urandom_range(9) < 6)
					d = $urandom_range(1, 300);
				else
					d = -$urandom_range(0, 300);
				sw = {16'd0, servo_thr_now} + 32'(d);
				if ($urandom_range(7) == 0)
					d = 0;
				else if ($urandom_range(1))
					d = $urandom_range(1, 300);
				else
					d = -$urandom_range(1, 300);
				ew = {16'd0, esc_thr_now} + 32'(d);
				send_evt(2'b01, t0, cur_ms);
				send_evt(2'b11, t0 + $urandom_range(15), cur_ms);
				if (sw < ew) begin
					send_evt(2'b10, t0 + sw, cur_ms + $urandom_range(2));
					send_evt(2'b00, t0 + ew, cur_ms + $urandom_range(2, 3));
				end else if (sw > ew) begin
					send_evt(2'b01, t0 + ew, cur_ms + $urandom_range(2));
					send_evt(2'b00, t0 + sw, cur_ms + $urandom_range(2, 3));
				end else begin
					send_evt(2'b00, t0 + sw, cur_ms + $urandom_range(2));
				end
				cur_us = t0 + 32'd2000;
			end
		end
	endtask

	// Hard stop in case a handshake never completes
	initial begin
		#(20_000_000);
		$display("timeout: %0d events sent, %0d results checked", n_sent, checked_cnt);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [15:0] s_thr;
		logic [15:0] e_thr;
		logic [7:0]  lim;
		arst_n            = 1'b0;
		evt_ch.valid      = 1'b0;
		evt_ch.data       = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.data       = '0;
		cur_us            = 32'd0;
		cur_ms            = 32'd0;
		servo_thr_now     = SERVO_LONG_THR_RST;
		esc_thr_now       = ESC_RUN_THR_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		src_idle_pct = 6;
		snk_idle_pct = 51;
		// Directed pass at reset thresholds (1500 / 1400 / 10).
		// No edge at all: held values come back.
		send_evt(2'b00, 32'd5, 32'd1);
		// Short frame; ESC below threshold starts the ESC clock.
		send_evt(2'b01, 32'd1000, 32'd10);
		send_evt(2'b11, 32'd1100, 32'd10);
		send_evt(2'b10, 32'd2000, 32'd11);
		send_evt(2'b00, 32'd2100, 32'd12);
		// Long servo pulse while dethermal is not started: counter must not move.
		send_evt(2'b11, 32'd21000, 32'd30);
		send_evt(2'b10, 32'd23000, 32'd32);
		// Running ESC pulse: motor time updated, dethermal start copied.
		send_evt(2'b00, 32'd23000, 32'd40);
		// Both lines fall together: servo handled before ESC.
		send_evt(2'b11, 32'd41000, 32'd50);
		send_evt(2'b00, 32'd43000, 32'd52);
		// ESC width exactly at threshold, then servo width exactly at threshold.
		send_evt(2'b11, 32'd61000, 32'd60);
		send_evt(2'b01, 32'd62400, 32'd61);
		send_evt(2'b00, 32'd62500, 32'd62);
		// Timestamp wrap on the microsecond clock, millisecond clock at its maximum.
		send_evt(2'b01, 32'hFFFF_FF00, 32'd70);
		send_evt(2'b00, 32'h0000_0100, 32'hFFFF_FFFF);
		// Field extremes.
		send_evt(2'b11, 32'hFFFF_FFFF, 32'd0);
		send_evt(2'b00, 32'd0, 32'hFFFF_FFFF);
		send_evt(2'b10, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_evt(2'b01, 32'd0, 32'd0);
		cur_us = 32'd100;
		cur_ms = 32'd100;

		// Random part: five threshold settings, each through three idle modes
		for (int k = 0; k < 5; k++) begin
			case (k)
				0: begin s_thr = SERVO_LONG_THR_RST; e_thr = ESC_RUN_THR_RST; lim = DT_LIMIT_RST; end
				1: begin s_thr = 16'd0;     e_thr = 16'd0;     lim = 8'd0;   end
				2: begin s_thr = 16'hFFFF;  e_thr = 16'hFFFF;  lim = 8'd255; end
				default: begin
					s_thr = 16'($urandom_range(800, 2200));
					e_thr = 16'($urandom_range(800, 2200));
					lim   = 8'($urandom_range(15));
				end
			endcase
			apply_setting(s_thr, e_thr, lim);
			for (int m = 0; m < 3; m++) begin
				src_idle_pct = (m == 0) ? 6 : (m == 1) ? 51 : 0;
				snk_idle_pct = (m == 0) ? 51 : (m == 1) ? 6 : 0;
				run_frames(103);
			end
		end

		// Drain: stop sending, wait for every pending result, then a short tail
		evt_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);

		$display("%0d pin-change events over 5 threshold settings, %0d results compared",
			n_sent, checked_cnt);
		$display("%0d mismatching or unexpected results, %0d results never seen",
			mismatch_cnt, outstanding);
		if (mismatch_cnt == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
hdl/rcpd_pkg.sv
hdl/rcpd_if.sv
hdl/rcpd_update.sv
hdl/rc_pulse_capture_dethermal_core.sv
tb/sv/rcpd_capture_checker.sv
tb/sv/tb_rc_pulse_capture_dethermal_core.sv
